// File: design/sjis_pkg.sv
// ----------------------------------------------------------------------------
// sjis_pkg
// Shared constants, range table and a helper for the Shift-JIS glyph address
// stream.
// ----------------------------------------------------------------------------
package sjis_pkg;

  // glyph cell geometry defaults
  localparam int unsigned CELL_WIDTH_DEFAULT      = 16;
  localparam int unsigned BYTES_PER_PIXEL_DEFAULT = 4;
  localparam int unsigned CELLS_PER_ROW           = 16;
  localparam int unsigned COL_BITS                = $clog2(CELLS_PER_ROW);

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned LINE_W   = 20;
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned BASE_W   = 9;
  localparam int unsigned PROD_W   = LINE_W + BASE_W;

  // codes drawn as blank cells
  localparam logic [CODE_W-1:0] HALF_SPACE = 16'h0020;
  localparam logic [CODE_W-1:0] FULL_SPACE = 16'h8140;

  // offset bias added to every glyph start
  localparam logic [OFFSET_W-1:0] START_BIAS = 32'd16;

  // code range table, later entries take priority
  localparam int unsigned RANGE_COUNT = 5;
  localparam logic [CODE_W-1:0] RANGE_FIRST [RANGE_COUNT] =
    '{16'h0020, 16'h00A0, 16'h8140, 16'h8740, 16'h8890};
  localparam logic [CODE_W-1:0] RANGE_LAST [RANGE_COUNT] =
    '{16'h00DF, 16'h00DF, 16'h84BF, 16'h879F, 16'h987F};
  localparam logic [BASE_W-1:0] RANGE_BASE [RANGE_COUNT] =
    '{9'd328, 9'd320, 9'd316, 9'd284, 9'd254};

  // lead byte ranges 0x81-0x9f and 0xe0-0xef
  function automatic logic is_lead(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] t;
    t = (b ^ 8'h20) - 8'hA1;
    return t < 8'd47;
  endfunction

endpackage

// File: design/sjis_glyph_address_stream_core.sv
// ----------------------------------------------------------------------------
// sjis_glyph_address_stream_core
// Shift-JIS byte stream to glyph code and font bitmap byte offset.
//
//   channel   direction  signals                                  beat
//   in        input      in_valid in_ready in_byte                one byte
//   cfg       input      cfg_valid cfg_ready line_bytes           row size
//   out       output     out_valid out_ready char_code            one glyph
//                        glyph_offset blank
//
// One byte per cycle is taken while in_ready is high; a completed code goes
// from the decode register, loaded when its last byte is accepted, through
// lookup and multiply into the result register once that register can take
// it. Lead bytes and zero bytes give no beat. Reset drops any pending lead
// and clears line_bytes. Ready of each stage follows the next one, so a
// stalled output fills both registers before in_ready falls.
// ----------------------------------------------------------------------------
module sjis_glyph_address_stream_core #(
  parameter int unsigned CELL_WIDTH      = sjis_pkg::CELL_WIDTH_DEFAULT,
  parameter int unsigned BYTES_PER_PIXEL = sjis_pkg::BYTES_PER_PIXEL_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sjis_pkg::LINE_W-1:0]    line_bytes,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sjis_pkg::BYTE_W-1:0]    in_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sjis_pkg::CODE_W-1:0]    char_code,
  output logic [sjis_pkg::OFFSET_W-1:0]  glyph_offset,
  output logic                           blank
);

  logic [sjis_pkg::LINE_W-1:0] line_bytes_reg;
  logic                        code_valid;
  logic                        code_ready;
  logic [sjis_pkg::CODE_W-1:0] code;

  // row size register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      line_bytes_reg <= line_bytes;
    end
  end

  // byte decode stage
  sjis_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .code       (code)
  );

  // offset stage
  sjis_locate #(
    .CELL_WIDTH      (CELL_WIDTH),
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
  ) u_locate (
    .clk          (clk),
    .rst          (rst),
    .line_bytes   (line_bytes_reg),
    .code_valid   (code_valid),
    .code_ready   (code_ready),
    .code         (code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .char_code    (char_code),
    .glyph_offset (glyph_offset),
    .blank        (blank)
  );

endmodule

// File: design/sjis_decode.sv
// ----------------------------------------------------------------------------
// sjis_decode
// Byte stage: joins lead and trail bytes into character codes and registers
// each completed code.
// ----------------------------------------------------------------------------
module sjis_decode (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sjis_pkg::BYTE_W-1:0]  in_byte,
  output logic                         code_valid,
  input  logic                         code_ready,
  output logic [sjis_pkg::CODE_W-1:0]  code
);

  logic                        lead_pending;
  logic [sjis_pkg::BYTE_W-1:0] held_lead;
  logic                        accept;
  logic                        produce;
  logic [sjis_pkg::CODE_W-1:0] code_next;

  // stage can take a beat when empty or draining
  assign in_ready = !code_valid || code_ready;
  assign accept   = in_valid && in_ready;

  // code assembly
  always_comb begin
    produce   = 1'b0;
    code_next = {{(sjis_pkg::CODE_W-sjis_pkg::BYTE_W){1'b0}}, in_byte};
    if (in_byte != '0) begin
      if (lead_pending) begin
        produce   = 1'b1;
        code_next = {held_lead, in_byte};
      end else if (!sjis_pkg::is_lead(in_byte)) begin
        produce = 1'b1;
      end
    end
  end

  // lead state
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending <= 1'b0;
      held_lead    <= '0;
    end else if (accept) begin
      if (in_byte == '0 || lead_pending) begin
        lead_pending <= 1'b0;
        held_lead    <= '0;
      end else if (sjis_pkg::is_lead(in_byte)) begin
        lead_pending <= 1'b1;
        held_lead    <= in_byte;
      end
    end
  end

  // code register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else begin
      code_valid <= (code_valid && !code_ready) || (accept && produce);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      code <= code_next;
    end
  end

endmodule

// File: design/sjis_locate.sv
// ----------------------------------------------------------------------------
// sjis_locate
// Result stage: range lookup, row and column terms and the glyph offset,
// held in the output register.
// ----------------------------------------------------------------------------
module sjis_locate #(
  parameter int unsigned CELL_WIDTH      = sjis_pkg::CELL_WIDTH_DEFAULT,
  parameter int unsigned BYTES_PER_PIXEL = sjis_pkg::BYTES_PER_PIXEL_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [sjis_pkg::LINE_W-1:0]    line_bytes,
  input  logic                           code_valid,
  output logic                           code_ready,
  input  logic [sjis_pkg::CODE_W-1:0]    code,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sjis_pkg::CODE_W-1:0]    char_code,
  output logic [sjis_pkg::OFFSET_W-1:0]  glyph_offset,
  output logic                           blank
);

  localparam int unsigned CELL_BYTES = CELL_WIDTH * BYTES_PER_PIXEL;

  logic                            accept;
  logic                            found;
  logic [sjis_pkg::CODE_W-1:0]     diff;
  logic [sjis_pkg::BASE_W-1:0]     rows_left;
  logic [sjis_pkg::COL_BITS-1:0]   col;
  logic [sjis_pkg::COL_BITS:0]     cols_left;
  logic [sjis_pkg::PROD_W-1:0]     row_prod;
  logic [sjis_pkg::OFFSET_W-1:0]   col_term;
  logic                            blank_next;
  logic [sjis_pkg::OFFSET_W-1:0]   offset_next;

  assign code_ready = !out_valid || out_ready;
  assign accept     = code_valid && code_ready;

  // range lookup, last matching entry wins
  always_comb begin
    found     = 1'b0;
    rows_left = '0;
    col       = '0;
    diff      = '0;
    for (int i = 0; i < sjis_pkg::RANGE_COUNT; i++) begin
      if (code >= sjis_pkg::RANGE_FIRST[i] && code <= sjis_pkg::RANGE_LAST[i]) begin
        found     = 1'b1;
        diff      = code - sjis_pkg::RANGE_FIRST[i];
        rows_left = sjis_pkg::RANGE_BASE[i]
                  - sjis_pkg::BASE_W'(diff[sjis_pkg::COL_BITS +: sjis_pkg::ROW_W]);
        col       = diff[sjis_pkg::COL_BITS-1:0];
      end
    end
  end

  // offset = line_bytes * (base - row) + bias - (cells - col) * cell bytes
  always_comb begin
    cols_left   = (sjis_pkg::COL_BITS+1)'(sjis_pkg::CELLS_PER_ROW)
                - {1'b0, col};
    row_prod    = sjis_pkg::PROD_W'(line_bytes) * sjis_pkg::PROD_W'(rows_left);
    col_term    = sjis_pkg::OFFSET_W'(cols_left) * sjis_pkg::OFFSET_W'(CELL_BYTES);
    blank_next  = !found || code == sjis_pkg::HALF_SPACE || code == sjis_pkg::FULL_SPACE;
    offset_next = sjis_pkg::OFFSET_W'(row_prod) + sjis_pkg::START_BIAS - col_term;
    if (blank_next) begin
      offset_next = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !out_ready) || accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_code    <= code;
      glyph_offset <= offset_next;
      blank        <= blank_next;
    end
  end

endmodule

// File: bench/tb_sjis_glyph_address_stream_core.sv
// ----------------------------------------------------------------------------
// tb_sjis_glyph_address_stream_core
// Streams Shift-JIS bytes into the core and checks every glyph beat against
// a cycle-free predictor of code joining and range-table offset lookup.
// Directed bytes cover blanks, table edges, overlapping ranges, lead bytes
// used as trail bytes and string ends; random text then runs under several
// row sizes with random stalls on both channels and one long output hold.
// ----------------------------------------------------------------------------
module tb_sjis_glyph_address_stream_core;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam int unsigned PHASE_BYTES  = 65;
  localparam int unsigned PHASE_COUNT  = 6;

  // glyph geometry and table as seen by the predictor
  localparam int unsigned GRID_COLS  = 16;
  localparam int unsigned CELL_BYTES = 16 * 4;
  localparam logic [sjis_pkg::CODE_W-1:0] SP_HALF = 16'h0020;
  localparam logic [sjis_pkg::CODE_W-1:0] SP_FULL = 16'h8140;
  localparam logic [sjis_pkg::OFFSET_W-1:0] ORIGIN_BIAS = 32'd16;
  localparam int unsigned SPAN_COUNT = 5;
  localparam logic [sjis_pkg::CODE_W-1:0] SPAN_LO [SPAN_COUNT] =
    '{16'h0020, 16'h00A0, 16'h8140, 16'h8740, 16'h8890};
  localparam logic [sjis_pkg::CODE_W-1:0] SPAN_HI [SPAN_COUNT] =
    '{16'h00DF, 16'h00DF, 16'h84BF, 16'h879F, 16'h987F};
  localparam logic [sjis_pkg::OFFSET_W-1:0] SPAN_ROW0 [SPAN_COUNT] =
    '{32'd328, 32'd320, 32'd316, 32'd284, 32'd254};

  // directed text: blanks, table edges, overlap, lead as trail, dropped lead
  localparam int unsigned DIRECTED_N = 25;
  localparam logic [sjis_pkg::BYTE_W-1:0] DIRECTED [DIRECTED_N] = '{
    8'h20, 8'h41, 8'h1F, 8'hA1, 8'hDF, 8'hFF,
    8'h81, 8'h40, 8'h81, 8'h41, 8'h84, 8'hBF, 8'h87, 8'h40,
    8'h88, 8'h90, 8'h98, 8'h7F, 8'h9F, 8'h81, 8'h81, 8'h00,
    8'hEF, 8'hFF, 8'h00};

  typedef struct {
    logic [sjis_pkg::CODE_W-1:0]   code;
    logic [sjis_pkg::OFFSET_W-1:0] offset;
    logic                          blank;
  } glyph_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [sjis_pkg::LINE_W-1:0]   line_bytes = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [sjis_pkg::BYTE_W-1:0]   in_byte = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [sjis_pkg::CODE_W-1:0]   char_code;
  logic [sjis_pkg::OFFSET_W-1:0] glyph_offset;
  logic                          blank;

  // handshake flags registered at the rising edge
  logic in_acc = 1'b0;
  logic cfg_acc = 1'b0;

  logic [sjis_pkg::BYTE_W-1:0] text_q [$];
  glyph_t                      glyph_q [$];
  int                          queued_n = 0;
  int                          accepted_n = 0;
  int                          err_count = 0;
  int                          stall_cycles = 0;

  // predictor state
  logic [sjis_pkg::LINE_W-1:0] row_size = '0;
  logic                        lead_held = 1'b0;
  logic [sjis_pkg::BYTE_W-1:0] lead_byte = '0;

  // idling state of both sides
  int src_wait = 0;
  int src_run = 0;
  int sink_wait = 0;
  int sink_run = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  sjis_glyph_address_stream_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .line_bytes   (line_bytes),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .char_code    (char_code),
    .glyph_offset (glyph_offset),
    .blank        (blank)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly no gap, some short, a few long, now and then a run with none
  function automatic int idle_len(inout int run);
    int r;
    r = $urandom_range(0, 99);
    if (run > 0) begin
      run--;
      return 0;
    end
    if (r < 4) begin
      run = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit is_lead_byte(input logic [sjis_pkg::BYTE_W-1:0] b);
    return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hEF);
  endfunction

  // offset of a code's glyph cell, last matching span wins
  function automatic glyph_t glyph_lookup(input logic [sjis_pkg::CODE_W-1:0] code,
                                          input logic [sjis_pkg::LINE_W-1:0] rows);
    glyph_t                        g;
    logic [sjis_pkg::OFFSET_W-1:0] d;
    logic [sjis_pkg::OFFSET_W-1:0] row;
    logic [sjis_pkg::OFFSET_W-1:0] col;
    logic [sjis_pkg::OFFSET_W-1:0] rows32;
    g.code = code;
    g.offset = '0;
    g.blank = 1'b1;
    rows32 = sjis_pkg::OFFSET_W'(rows);
    if (code == SP_HALF || code == SP_FULL) return g;
    for (int i = 0; i < SPAN_COUNT; i++) begin
      if (code >= SPAN_LO[i] && code <= SPAN_HI[i]) begin
        d = sjis_pkg::OFFSET_W'(code - SPAN_LO[i]);
        row = d / GRID_COLS;
        col = d % GRID_COLS;
        g.offset = rows32 * SPAN_ROW0[i] + ORIGIN_BIAS - rows32 * row
                   - (GRID_COLS - col) * CELL_BYTES;
        g.blank = 1'b0;
      end
    end
    return g;
  endfunction

  function automatic void push_byte(input logic [sjis_pkg::BYTE_W-1:0] b);
    text_q.push_back(b);
    queued_n++;
  endfunction

  // random text: mostly well-formed characters, some string ends and noise
  function automatic void queue_text(input int n);
    int                          start_n;
    int                          kind;
    int                          span;
    logic [sjis_pkg::CODE_W-1:0] code;
    start_n = queued_n;
    while (queued_n - start_n < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        if ($urandom_range(0, 9) == 0) push_byte(8'h20);
        else if ($urandom_range(0, 1))
          push_byte(sjis_pkg::BYTE_W'($urandom_range(8'h21, 8'h7F)));
        else push_byte(sjis_pkg::BYTE_W'($urandom_range(8'hA0, 8'hDF)));
      end else if (kind < 70) begin
        span = $urandom_range(2, 4);
        code = sjis_pkg::CODE_W'(SPAN_LO[span] +
                                 $urandom_range(0, SPAN_HI[span] - SPAN_LO[span]));
        if ($urandom_range(0, 9) == 0) code = SP_FULL;
        push_byte(code[15:8]);
        push_byte(code[7:0]);
      end else if (kind < 85) begin
        if ($urandom_range(0, 2) == 0)
          push_byte(sjis_pkg::BYTE_W'($urandom_range(8'hE0, 8'hEF)));
        else push_byte(sjis_pkg::BYTE_W'($urandom_range(8'h81, 8'h9F)));
        push_byte(sjis_pkg::BYTE_W'($urandom_range(1, 255)));
      end else if (kind < 93) begin
        if ($urandom_range(0, 1))
          push_byte(sjis_pkg::BYTE_W'($urandom_range(8'h81, 8'h9F)));
        push_byte(8'h00);
      end else begin
        push_byte(sjis_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (accepted_n != queued_n || glyph_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_line_bytes(input logic [sjis_pkg::LINE_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    line_bytes <= v;
    do @(negedge clk); while (!cfg_acc);
    cfg_valid <= 1'b0;
  endtask

  // byte source
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_acc) begin
        // beat still on offer
      end else if (src_wait > 0) begin
        src_wait--;
        in_valid <= 1'b0;
      end else if (text_q.size() > 0) begin
        in_valid <= 1'b1;
        in_byte <= text_q.pop_front();
        src_wait = idle_len(src_run);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // glyph sink, with a long hold when asked
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        sink_wait = idle_len(sink_run);
      end
    end
  end

  // predict on accepted bytes, check glyph beats in order
  always @(posedge clk) begin
    glyph_t                      want;
    logic [sjis_pkg::BYTE_W-1:0] b;
    in_acc <= in_valid && in_ready;
    cfg_acc <= cfg_valid && cfg_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) row_size = line_bytes;
      if (in_valid && in_ready) begin
        accepted_n++;
        b = in_byte;
        if (b == 8'h00) begin
          lead_held = 1'b0;
          lead_byte = '0;
        end else if (lead_held) begin
          glyph_q.push_back(glyph_lookup({lead_byte, b}, row_size));
          lead_held = 1'b0;
          lead_byte = '0;
        end else if (is_lead_byte(b)) begin
          lead_held = 1'b1;
          lead_byte = b;
        end else begin
          glyph_q.push_back(glyph_lookup({8'h00, b}, row_size));
        end
      end
      if (out_valid && out_ready) begin
        if (glyph_q.size() == 0) begin
          $error("glyph beat with nothing expected: char_code %h", char_code);
          err_count++;
        end else begin
          want = glyph_q.pop_front();
          if (char_code !== want.code) begin
            $error("char_code: expected %h, got %h", want.code, char_code);
            err_count++;
          end
          if (glyph_offset !== want.offset) begin
            $error("glyph_offset: expected %h, got %h", want.offset, glyph_offset);
            err_count++;
          end
          if (blank !== want.blank) begin
            $error("blank: expected %b, got %b", want.blank, blank);
            err_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // phases: directed text at the reset row size, then random text per setting
  initial begin
    logic [sjis_pkg::LINE_W-1:0] settings [PHASE_COUNT];
    settings = '{20'hFFFFF, 20'h00001, 20'h00000, 20'h80000, 20'h00000, 20'h00000};
    settings[2] = sjis_pkg::LINE_W'($urandom_range(2, 20'hFFFFE));
    settings[5] = sjis_pkg::LINE_W'($urandom_range(1, 20'h00FFF));
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED[k]) push_byte(DIRECTED[k]);
    wait_drained();
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_line_bytes(settings[p]);
      @(posedge clk);
      // sink holds off while text keeps coming, so the core backs up
      if (p == 2) hold_req <= hold_req + 1;
      queue_text(PHASE_BYTES);
      wait_drained();
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
